@@ design/gregorian_date_decrement_defines.svh @@
// ----------------------------------------------------------------------------
// Gregorian date decrement assertion macros
// Shared property macros for the checks at the end of the date decrement block.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_DECREMENT_DEFINES_SVH
`define GREGORIAN_DATE_DECREMENT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define GDD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define GDD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/gdd_pkg.sv @@
// ----------------------------------------------------------------------------
// Gregorian date decrement package
// Operation codes, calendar constants and the month length and inverse helpers.
// ----------------------------------------------------------------------------
package gdd_pkg;

    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int MONTHS_PER_YEAR    = 12;
    localparam int FEB_SHORT_DAYS     = 28;

    localparam logic [1:0] OP_DAYS         = 2'd0;
    localparam logic [1:0] OP_MONTHS_STEP  = 2'd1;
    localparam logic [1:0] OP_YEARS_STEP   = 2'd2;
    localparam logic [1:0] OP_YEARS_DIRECT = 2'd3;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [4:0] DAYS_LONG  = 5'd31;
    localparam logic [4:0] DAYS_SHORT = 5'd30;
    localparam logic [4:0] DAYS_FEB   = 5'd28;
    localparam logic [4:0] DAYS_LEAP  = 5'd29;

    function automatic logic [31:0] inv_odd(input logic [31:0] a);
        logic [31:0] x;
        x = a;
        for (int i = 0; i < 5; i++)
        begin
            x = x * (32'd2 - a * x);
        end
        return x;
    endfunction

    localparam int          ABS_BITS    = 17;
    localparam logic [16:0] INV25       = 17'(inv_odd(32'd25));
    localparam logic [16:0] DIV25_LIMIT = 17'(((1 << ABS_BITS) - 1) / 25);

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: n = DAYS_SHORT;
            MONTH_FEB:               n = leap ? DAYS_LEAP : DAYS_FEB;
            default:                 n = DAYS_LONG;
        endcase
        return n;
    endfunction

endpackage

@@ design/gregorian_date_decrement.sv @@
// ----------------------------------------------------------------------------
// Gregorian date decrement
// Steps a date back by days, months or years with one shared decrement path.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  request   req_valid, req_stall  operation, day, month, year, count
//  result    res_valid, res_stall  result_day, result_month, result_year
//
//  Days go back one month border or one partial month per step of the sequencer.
//  Months go back one month per step, or twelve months once the day is 28 or less.
//  Stepwise years step single years through a clamp step; direct years subtract the count, then clamp.
//  All of these run on the single day, month and year decrement register path.
//  Reset clears the sequencer and the result valid flag.
//  A new request is taken while an earlier result still waits on res_stall.
`include "gregorian_date_decrement_defines.svh"

module gregorian_date_decrement
    import gdd_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [1:0]         operation,
    input  logic [4:0]         day,
    input  logic [3:0]         month,
    input  logic signed [15:0] year,
    input  logic [15:0]        count,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [4:0]         result_day,
    output logic [3:0]         result_month,
    output logic signed [15:0] result_year
);

    localparam int CW = (COUNT_BITS > 5) ? COUNT_BITS : 5;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_CLAMP = 4'b0100,
        ST_HOLD  = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [1:0]              op_reg, op_next;
    logic [4:0]              day_reg, day_next;
    logic [3:0]              month_reg, month_next;
    logic signed [15:0]      year_reg, year_next;
    logic [COUNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                    brk_reg, brk_next;
    logic                    res_valid_reg, res_valid_next;
    logic [4:0]              res_day_reg, res_day_next;
    logic [3:0]              res_month_reg, res_month_next;
    logic signed [15:0]      res_year_reg, res_year_next;

    logic [16:0]             year_abs;
    logic [16:0]             year_prod;
    logic                    leap;
    logic [4:0]              cur_len;
    logic [4:0]              prev_len;
    logic [4:0]              day_m1;
    logic [15:0]             cnt16;
    logic                    accept;
    logic                    res_free;

    // Divisibility by 25 uses the modular inverse on the magnitude of the year.
    always_comb
    begin
        year_abs  = year_reg[15] ? 17'(-{year_reg[15], year_reg}) : {1'b0, year_reg};
        year_prod = year_abs * INV25;
        leap      = (year_reg[1:0] == 2'd0)
                    && ((year_reg[3:0] == 4'd0) || (year_prod > DIV25_LIMIT));
    end

    assign cur_len  = month_len(month_reg, leap);
    assign prev_len = month_len(month_reg - 4'd1, leap);
    assign day_m1   = day_reg - 5'd1;
    assign cnt16    = 16'(cnt_reg);
    assign accept   = req_valid && !req_stall;
    assign res_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        cnt_next       = cnt_reg;
        brk_next       = brk_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_day_next   = res_day_reg;
        res_month_next = res_month_reg;
        res_year_next  = res_year_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = operation;
                    day_next   = (day == 5'd0) ? 5'd1 : day;
                    month_next = (month == 4'd0) ? MONTH_JAN
                               : ((month > MONTH_DEC) ? MONTH_DEC : month);
                    year_next  = year;
                    cnt_next   = COUNT_BITS'(count);
                    brk_next   = 1'b0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                case (op_reg)
                    OP_DAYS:
                    begin
                        if (cnt_reg == '0)
                        begin
                            state_next = ST_HOLD;
                        end
                        else if (day_reg > 5'd1)
                        begin
                            if (CW'(cnt_reg) > CW'(day_m1))
                            begin
                                day_next = 5'd1;
                                cnt_next = cnt_reg - COUNT_BITS'(day_m1);
                            end
                            else
                            begin
                                day_next = day_reg - 5'(cnt_reg);
                                cnt_next = '0;
                            end
                        end
                        else
                        begin
                            if (month_reg == MONTH_JAN)
                            begin
                                month_next = MONTH_DEC;
                                day_next   = DAYS_LONG;
                                year_next  = year_reg - 16'sd1;
                            end
                            else
                            begin
                                month_next = month_reg - 4'd1;
                                day_next   = prev_len;
                            end
                            cnt_next = cnt_reg - COUNT_BITS'(1);
                        end
                    end
                    OP_MONTHS_STEP:
                    begin
                        if (cnt_reg == '0)
                        begin
                            state_next = ST_HOLD;
                        end
                        else if ((day_reg <= 5'(FEB_SHORT_DAYS))
                                 && (cnt_reg >= COUNT_BITS'(MONTHS_PER_YEAR)))
                        begin
                            year_next = year_reg - 16'sd1;
                            cnt_next  = cnt_reg - COUNT_BITS'(MONTHS_PER_YEAR);
                        end
                        else
                        begin
                            if (month_reg == MONTH_JAN)
                            begin
                                month_next = MONTH_DEC;
                                year_next  = year_reg - 16'sd1;
                            end
                            else
                            begin
                                month_next = month_reg - 4'd1;
                                day_next   = (day_reg > prev_len) ? prev_len : day_reg;
                            end
                            cnt_next = cnt_reg - COUNT_BITS'(1);
                        end
                    end
                    OP_YEARS_STEP:
                    begin
                        if ((cnt_reg != '0) && !brk_reg
                            && ((month_reg == MONTH_FEB) ? (day_reg > DAYS_FEB)
                                                         : (day_reg >= cur_len)))
                        begin
                            year_next  = year_reg - 16'sd1;
                            cnt_next   = cnt_reg - COUNT_BITS'(1);
                            state_next = ST_CLAMP;
                        end
                        else
                        begin
                            year_next  = year_reg - signed'(cnt16);
                            cnt_next   = '0;
                            state_next = ST_HOLD;
                        end
                    end
                    default:
                    begin
                        year_next  = year_reg - signed'(cnt16);
                        cnt_next   = '0;
                        state_next = ST_CLAMP;
                    end
                endcase
            end
            ST_CLAMP:
            begin
                day_next = (day_reg > cur_len) ? cur_len : day_reg;
                if (op_reg == OP_YEARS_DIRECT)
                begin
                    state_next = ST_HOLD;
                end
                else
                begin
                    brk_next   = (month_reg != MONTH_FEB);
                    state_next = ST_RUN;
                end
            end
            ST_HOLD:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_day_next   = day_reg;
                    res_month_next = month_reg;
                    res_year_next  = year_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        day_reg       <= day_next;
        month_reg     <= month_next;
        year_reg      <= year_next;
        cnt_reg       <= cnt_next;
        brk_reg       <= brk_next;
        res_day_reg   <= res_day_next;
        res_month_reg <= res_month_next;
        res_year_reg  <= res_year_next;
    end

    assign req_stall    = (state_reg != ST_IDLE);
    assign res_valid    = res_valid_reg;
    assign result_day   = res_day_reg;
    assign result_month = res_month_reg;
    assign result_year  = res_year_reg;

    `GDD_ASSERT_NEXT(a_accept_starts_run, accept, state_reg == ST_RUN,
                     "accepted request did not start the sequencer")
    `GDD_ASSERT_NOW(a_result_in_range, res_valid,
                    (result_month >= MONTH_JAN) && (result_month <= MONTH_DEC)
                    && (result_day != 5'd0),
                    "result date out of range")
    `GDD_ASSERT_NOW(a_clamp_years_only, state_reg == ST_CLAMP,
                    (op_reg == OP_YEARS_STEP) || (op_reg == OP_YEARS_DIRECT),
                    "clamp step reached by a day or month operation")
    `GDD_ASSERT_NOW(a_run_day_nonzero, state_reg == ST_RUN,
                    (day_reg != 5'd0) && (month_reg != 4'd0) && (month_reg <= MONTH_DEC),
                    "working date lost its normal form")

endmodule

@@ test/gregorian_date_decrement_checker.sv @@
// ----------------------------------------------------------------------------
// Gregorian date decrement checker
// Watches the request and result channels of the date decrement block, works
// out the earlier date for every accepted request and compares each accepted
// result with the oldest date still awaited.
// ----------------------------------------------------------------------------
module gregorian_date_decrement_checker
    import gdd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_stall,
    input  logic [1:0]         operation,
    input  logic [4:0]         day,
    input  logic [3:0]         month,
    input  logic signed [15:0] year,
    input  logic [15:0]        count,
    input  logic               res_valid,
    input  logic               res_stall,
    input  logic [4:0]         result_day,
    input  logic [3:0]         result_month,
    input  logic signed [15:0] result_year,
    output int                 fail_count,
    output int                 outstanding,
    output int                 results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
    } date_t;

    date_t expected_dates[$];

    initial
    begin
        fail_count      = 0;
        outstanding     = 0;
        results_checked = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    function automatic bit leap_year(input logic [15:0] y);
        int yr;
        yr = $signed(y);
        return (yr % 400 == 0) || (yr % 4 == 0 && yr % 100 != 0);
    endfunction

    function automatic int days_in(input int m, input logic [15:0] y);
        int n;
        case (m)
            4, 6, 9, 11: n = 30;
            MONTH_FEB:   n = leap_year(y) ? 29 : 28;
            default:     n = 31;
        endcase
        return n;
    endfunction

    function automatic date_t earlier_date(input logic [1:0] op, input logic [4:0] day_in,
                                           input logic [3:0] month_in,
                                           input logic [15:0] year_in,
                                           input logic [15:0] count_in);
        date_t       r;
        int          d;
        int          m;
        int          n;
        int          t;
        int          q;
        int          rem;
        int          left;
        bit          done;
        logic [15:0] y;
        d    = day_in;
        m    = month_in;
        y    = year_in;
        left = count_in;
        if (m < 1)
            m = 1;
        if (m > MONTHS_PER_YEAR)
            m = MONTHS_PER_YEAR;
        if (d < 1)
            d = 1;
        case (op)
            OP_DAYS:
            begin
                while (left > 0)
                begin
                    if (d > 1)
                    begin
                        t = (d - 1 < left) ? d - 1 : left;
                        d = d - t;
                        left = left - t;
                    end
                    else
                    begin
                        if (m == MONTH_JAN)
                        begin
                            m = MONTH_DEC;
                            d = DAYS_LONG;
                            y = y - 16'd1;
                        end
                        else
                        begin
                            m = m - 1;
                            d = days_in(m, y);
                        end
                        left = left - 1;
                    end
                end
            end
            OP_MONTHS_STEP:
            begin
                while (left > 0 && d > FEB_SHORT_DAYS)
                begin
                    if (m == MONTH_JAN)
                    begin
                        m = MONTH_DEC;
                        y = y - 16'd1;
                    end
                    else
                    begin
                        m = m - 1;
                    end
                    n = days_in(m, y);
                    if (d > n)
                        d = n;
                    left = left - 1;
                end
                if (left > 0)
                begin
                    q   = left / MONTHS_PER_YEAR;
                    rem = left % MONTHS_PER_YEAR;
                    if (m <= rem)
                    begin
                        m = m + MONTHS_PER_YEAR - rem;
                        q = q + 1;
                    end
                    else
                    begin
                        m = m - rem;
                    end
                    y = y - q[15:0];
                end
            end
            OP_YEARS_STEP:
            begin
                done = 1'b0;
                while (!done && left > 0 &&
                       d > ((m == MONTH_FEB) ? FEB_SHORT_DAYS : days_in(m, y) - 1))
                begin
                    y = y - 16'd1;
                    n = days_in(m, y);
                    if (d > n)
                        d = n;
                    left = left - 1;
                    if (m != MONTH_FEB)
                        done = 1'b1;
                end
                y = y - left[15:0];
            end
            default:
            begin
                y = y - left[15:0];
                n = days_in(m, y);
                if (d > n)
                    d = n;
            end
        endcase
        r.day   = d[4:0];
        r.month = m[3:0];
        r.year  = y;
        return r;
    endfunction

    always @(posedge clk)
    begin : track
        date_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_dates.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d/%0d/%0d with no request pending",
                                              result_day, result_month, result_year));
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (result_day !== want.day)
                        report_mismatch($sformatf("result_day %0d, predicted %0d",
                                                  result_day, want.day));
                    if (result_month !== want.month)
                        report_mismatch($sformatf("result_month %0d, predicted %0d",
                                                  result_month, want.month));
                    if (result_year !== want.year)
                        report_mismatch($sformatf("result_year %0d, predicted %0d",
                                                  result_year, $signed(want.year)));
                    results_checked++;
                end
            end
            if (req_valid && !req_stall)
                expected_dates.push_back(earlier_date(operation, day, month, year, count));
        end
        outstanding = expected_dates.size();
    end

endmodule

@@ test/gregorian_date_decrement_tb.sv @@
// ----------------------------------------------------------------------------
// Gregorian date decrement testbench
// Drives directed and random date requests through all four operations with
// random idling on both channels; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module gregorian_date_decrement_tb
    import gdd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 100;
    localparam int CYCLE_LIMIT     = 4000000;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    logic [1:0]         operation;
    logic [4:0]         day;
    logic [3:0]         month;
    logic signed [15:0] year;
    logic [15:0]        count;
    logic               res_valid;
    logic               res_stall;
    logic [4:0]         result_day;
    logic [3:0]         result_month;
    logic signed [15:0] result_year;

    int fail_count;
    int outstanding;
    int results_checked;
    int requests_sent;
    int idle_pct;
    int cycles;

    gregorian_date_decrement i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .operation    (operation),
        .day          (day),
        .month        (month),
        .year         (year),
        .count        (count),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .result_day   (result_day),
        .result_month (result_month),
        .result_year  (result_year)
    );

    gregorian_date_decrement_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .operation       (operation),
        .day             (day),
        .month           (month),
        .year            (year),
        .count           (count),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .result_day      (result_day),
        .result_month    (result_month),
        .result_year     (result_year),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Run stopped after %0d cycles with %0d results still awaited.",
                 cycles, outstanding);
        $display("gregorian_date_decrement verification failed");
        $finish;
    end

    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            res_stall <= (idle_pct != 0) && ($urandom_range(0, 99) < idle_pct);
        end
    end

    task automatic send_request(input logic [1:0] op, input int d, input int m,
                                input int yr, input int c);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        operation <= op;
        day       <= d[4:0];
        month     <= m[3:0];
        year      <= yr[15:0];
        count     <= c[15:0];
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic random_request();
        logic [1:0] op;
        int         d;
        int         m;
        int         yr;
        int         c;
        int         pick;
        op   = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            d = $urandom_range(0, 31);
        else if (pick < 5)
            d = $urandom_range(28, 31);
        else
            d = $urandom_range(1, 31);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            m = $urandom_range(0, 15);
        else if (pick < 4)
            m = $urandom_range(1, 3);
        else
            m = $urandom_range(1, 12);
        pick = $urandom_range(0, 9);
        if (pick < 3)
            yr = $urandom_range(0, 65535);
        else if (pick == 3)
            yr = -32768 + $urandom_range(0, 8);
        else
            yr = $urandom_range(0, 2800) - 800;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            c = $urandom_range(0, 65535);
        else if (pick < 3)
            c = $urandom_range(0, 8000);
        else if (pick < 8)
            c = $urandom_range(0, 1000);
        else
            c = $urandom_range(0, 60);
        send_request(op, d, m, yr, c);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        operation     = OP_DAYS;
        day           = 5'd1;
        month         = MONTH_JAN;
        year          = 16'sd0;
        count         = 16'd0;
        requests_sent = 0;
        idle_pct      = 13;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_DAYS, 1, 1, 0, 1);
        send_request(OP_DAYS, 1, 3, 2000, 1);
        send_request(OP_DAYS, 1, 3, 1900, 1);
        send_request(OP_DAYS, 1, 1, -32768, 1);
        send_request(OP_DAYS, 0, 0, -400, 0);
        send_request(OP_DAYS, 31, 15, 32767, 65535);
        send_request(OP_MONTHS_STEP, 31, 3, 2024, 1);
        send_request(OP_MONTHS_STEP, 31, 3, 2023, 1);
        send_request(OP_MONTHS_STEP, 31, 5, -100, 3);
        send_request(OP_MONTHS_STEP, 30, 1, -32768, 1);
        send_request(OP_MONTHS_STEP, 15, 7, 1, 65535);
        send_request(OP_MONTHS_STEP, 31, 2, 2023, 0);
        send_request(OP_YEARS_STEP, 29, 2, 2024, 1);
        send_request(OP_YEARS_STEP, 29, 2, 2024, 4);
        send_request(OP_YEARS_STEP, 31, 4, 1999, 1);
        send_request(OP_YEARS_STEP, 31, 2, 2023, 0);
        send_request(OP_YEARS_STEP, 31, 12, -32767, 65535);
        send_request(OP_YEARS_DIRECT, 29, 2, 2024, 0);
        send_request(OP_YEARS_DIRECT, 31, 2, 2023, 0);
        send_request(OP_YEARS_DIRECT, 29, 2, 2000, 100);
        send_request(OP_YEARS_DIRECT, 29, 2, 0, 4);
        send_request(OP_YEARS_DIRECT, 29, 2, 0, 100);
        send_request(OP_YEARS_DIRECT, 31, 11, -1, 65535);
        send_request(OP_YEARS_DIRECT, 0, 13, 12, 5);
        wait_drained();

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            idle_pct = (i >= 30 && i < 60) ? 0 : 13;
            random_request();
        end
        idle_pct = 13;
        wait_drained();
        repeat (20) @(posedge clk);

        $display("Sent %0d date requests across all four operations, including leap, month-end,",
                 requests_sent);
        $display("out-of-range and year-wrap cases; %0d results were compared.", results_checked);
        if (fail_count == 0 && outstanding == 0)
            $display("gregorian_date_decrement verification clean");
        else
            $display("gregorian_date_decrement verification failed");
        $finish;
    end

endmodule
